FILE: src/accr_pkg.sv
// Shared types, constants and palette functions for the cell colour resolver.
`timescale 1ns / 1ps
`default_nettype none

package accr_pkg;

  typedef enum logic [1:0] {
    CMD_RESOLVE = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RELOAD  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_DEFAULT = 2'd0,
    SRC_INDEXED = 2'd1,
    SRC_RGB     = 2'd2
  } src_e;

  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  localparam int unsigned BaseEntries = 16;
  localparam int unsigned BaseIdxW    = 4;

  localparam logic [23:0] DEFAULT_FG_RST = 24'hC8CBCD;
  localparam logic [23:0] DEFAULT_BG_RST = 24'h000000;

  localparam logic [7:0] GREY_START  = 8'd232;
  localparam logic [7:0] FAINT_ALPHA = 8'd150;
  localparam logic [7:0] FULL_ALPHA  = 8'd255;

  localparam logic [23:0] DARK_TABLE [BaseEntries] = '{
    24'h3B3F44, 24'hD26B6B, 24'h8FB86C, 24'hD4B06B,
    24'h5F9DD9, 24'hB283C6, 24'h5FB3B3, 24'hC8CBCD,
    24'h60666C, 24'hE88B8B, 24'hA8D086, 24'hE8C688,
    24'h82B8EA, 24'hCBA0DC, 24'h82CFCF, 24'hF0F2F4
  };

  localparam logic [23:0] LIGHT_TABLE [BaseEntries] = '{
    24'h2B2F33, 24'hB33333, 24'h3D6B22, 24'h926B00,
    24'h1F6FB2, 24'h86459C, 24'h277D7D, 24'h6B7076,
    24'h50555B, 24'hD03F3F, 24'h4D862B, 24'hB38400,
    24'h2A8ADB, 24'hA155BB, 24'h309999, 24'h1D1F21
  };

  function automatic logic [7:0] cube_level(input logic [2:0] n);
    logic [7:0] lvl;
    case (n)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  // Colour cube and grey ramp; only meaningful for indices 16..255.
  // v/36 by (v*57)>>11 and w/6 by (w*43)>>8, exact over their ranges.
  function automatic logic [23:0] fixed_color(input logic [7:0] idx);
    logic [7:0]  v;
    logic [13:0] p36;
    logic [2:0]  r;
    logic [5:0]  w;
    logic [10:0] p6;
    logic [2:0]  g;
    logic [2:0]  b;
    logic [7:0]  k;
    logic [7:0]  grey;
    v    = idx - 8'd16;
    p36  = 14'(v) * 14'd57;
    r    = p36[13:11];
    w    = 6'(v - 8'(r) * 8'd36);
    p6   = 11'(w) * 11'd43;
    g    = p6[10:8];
    b    = 3'(w - 6'(g) * 6'd6);
    k    = idx - GREY_START;
    grey = 8'd8 + 8'(k * 8'd10);
    if (idx >= GREY_START) begin
      return {grey, grey, grey};
    end
    return {cube_level(r), cube_level(g), cube_level(b)};
  endfunction

endpackage

`default_nettype wire

FILE: src/accr_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module accr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: src/ansi_cell_color_resolver_core.sv
// Top level of the cell colour resolver: palette state, resolve pipeline, config registers.
// done_o is registered: a taken start_i passes the input register, then the result register (resolve only).
// Throughput: one transaction per cycle; busy_o stays low, so start_i is always taken.
// Palette commands update state in the cycle after acceptance; a following resolve sees it.
// Reset: async, active low; base palette returns to the dark theme, customs invalid,
// defaults to their reset colours. No clearing pass, ready straight out of reset.
`timescale 1ns / 1ps
`default_nettype none

module ansi_cell_color_resolver_core
  import accr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [1:0]  fg_source_i,
  input  wire logic [7:0]  fg_index_i,
  input  wire logic [23:0] fg_rgb_i,
  input  wire logic [1:0]  bg_source_i,
  input  wire logic [7:0]  bg_index_i,
  input  wire logic [23:0] bg_rgb_i,
  input  wire logic        inverse_i,
  input  wire logic        faint_i,
  input  wire logic        dark_theme_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [23:0] entry_color_i,
  output logic             done_o,
  output logic [23:0]      fg_color_o,
  output logic [7:0]       fg_alpha_o,
  output logic [23:0]      bg_color_o,
  output logic             bg_visible_o
);

  typedef struct packed {
    cmd_e                cmd;
    logic [1:0]          fg_src;
    logic [7:0]          fg_idx;
    logic [23:0]         fg_rgb;
    logic [1:0]          bg_src;
    logic [7:0]          bg_idx;
    logic [23:0]         bg_rgb;
    logic                inverse;
    logic                faint;
    logic                dark;
    logic [BaseIdxW-1:0] entry;
    logic [23:0]         entry_color;
  } item_t;

  logic accept;

  logic  s1_valid_q;
  item_t s1_q;

  logic [23:0] default_fg_q;
  logic [23:0] default_bg_q;

  logic [BaseEntries-1:0] custom_valid_q, custom_valid_d;
  logic [BaseEntries-1:0] use_custom_q, use_custom_d;
  logic [BaseEntries-1:0] theme_dark_q, theme_dark_d;

  logic        ram_we;
  logic [23:0] ram_rd_a, ram_rd_b;
  logic        byp_a_q, byp_b_q;
  logic [23:0] byp_data_q;

  logic [23:0] cust_a, cust_b;
  logic [23:0] base_a, base_b;
  logic [23:0] pal_a, pal_b;
  logic [23:0] pick_a, pick_b;
  logic [23:0] fb_a, fb_b;

  logic        done_q;
  logic [23:0] fg_color_q, fg_color_d;
  logic [7:0]  fg_alpha_q, fg_alpha_d;
  logic [23:0] bg_color_q, bg_color_d;
  logic        bg_visible_q, bg_visible_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.cmd         <= cmd_e'(command_i);
      s1_q.fg_src      <= fg_source_i;
      s1_q.fg_idx      <= fg_index_i;
      s1_q.fg_rgb      <= fg_rgb_i;
      s1_q.bg_src      <= bg_source_i;
      s1_q.bg_idx      <= bg_index_i;
      s1_q.bg_rgb      <= bg_rgb_i;
      s1_q.inverse     <= inverse_i;
      s1_q.faint       <= faint_i;
      s1_q.dark        <= dark_theme_i;
      s1_q.entry       <= entry_index_i;
      s1_q.entry_color <= entry_color_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_fg_q <= DEFAULT_FG_RST;
      default_bg_q <= DEFAULT_BG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEFAULT_FG: default_fg_q <= cfg_wdata_i;
        CFG_DEFAULT_BG: default_bg_q <= cfg_wdata_i;
        default:        default_fg_q <= default_fg_q;
      endcase
    end
  end

  // Palette state: per entry, custom or theme table, and which theme
  always_comb begin
    custom_valid_d = custom_valid_q;
    use_custom_d   = use_custom_q;
    theme_dark_d   = theme_dark_q;
    if (s1_valid_q) begin
      unique case (s1_q.cmd)
        CMD_WRITE: begin
          custom_valid_d[s1_q.entry] = 1'b1;
          use_custom_d[s1_q.entry]   = 1'b1;
        end
        CMD_RELOAD: begin
          use_custom_d = custom_valid_q;
          theme_dark_d = {BaseEntries{s1_q.dark}};
        end
        CMD_CLEAR: begin
          custom_valid_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      custom_valid_q <= '0;
      use_custom_q   <= '0;
      theme_dark_q   <= '1;
    end else begin
      custom_valid_q <= custom_valid_d;
      use_custom_q   <= use_custom_d;
      theme_dark_q   <= theme_dark_d;
    end
  end

  assign ram_we = s1_valid_q && (s1_q.cmd == CMD_WRITE);

  accr_ram #(
    .WIDTH (24),
    .DEPTH (BaseEntries)
  ) u_custom_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s1_q.entry),
    .wdata_i   (s1_q.entry_color),
    .raddr_a_i (fg_index_i[BaseIdxW-1:0]),
    .rdata_a_o (ram_rd_a),
    .raddr_b_i (bg_index_i[BaseIdxW-1:0]),
    .rdata_b_o (ram_rd_b)
  );

  // Forward a custom write that lands on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
    end else begin
      byp_a_q <= ram_we && (s1_q.entry == fg_index_i[BaseIdxW-1:0]);
      byp_b_q <= ram_we && (s1_q.entry == bg_index_i[BaseIdxW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= s1_q.entry_color;
  end

  assign cust_a = byp_a_q ? byp_data_q : ram_rd_a;
  assign cust_b = byp_b_q ? byp_data_q : ram_rd_b;

  always_comb begin
    base_a = use_custom_q[s1_q.fg_idx[BaseIdxW-1:0]] ? cust_a :
             theme_dark_q[s1_q.fg_idx[BaseIdxW-1:0]] ? DARK_TABLE[s1_q.fg_idx[BaseIdxW-1:0]] :
             LIGHT_TABLE[s1_q.fg_idx[BaseIdxW-1:0]];
    base_b = use_custom_q[s1_q.bg_idx[BaseIdxW-1:0]] ? cust_b :
             theme_dark_q[s1_q.bg_idx[BaseIdxW-1:0]] ? DARK_TABLE[s1_q.bg_idx[BaseIdxW-1:0]] :
             LIGHT_TABLE[s1_q.bg_idx[BaseIdxW-1:0]];
    pal_a  = (s1_q.fg_idx < 8'(BaseEntries)) ? base_a : fixed_color(s1_q.fg_idx);
    pal_b  = (s1_q.bg_idx < 8'(BaseEntries)) ? base_b : fixed_color(s1_q.bg_idx);
  end

  // Fallbacks follow the output side, so they swap under inverse
  assign fb_a = s1_q.inverse ? default_bg_q : default_fg_q;
  assign fb_b = s1_q.inverse ? default_fg_q : default_bg_q;

  always_comb begin
    case (s1_q.fg_src)
      SRC_INDEXED: pick_a = pal_a;
      SRC_RGB:     pick_a = s1_q.fg_rgb;
      default:     pick_a = fb_a;
    endcase
    case (s1_q.bg_src)
      SRC_INDEXED: pick_b = pal_b;
      SRC_RGB:     pick_b = s1_q.bg_rgb;
      default:     pick_b = fb_b;
    endcase
  end

  always_comb begin
    if (s1_q.inverse) begin
      fg_color_d   = pick_b;
      fg_alpha_d   = FULL_ALPHA;
      bg_color_d   = pick_a;
      bg_visible_d = 1'b1;
    end else begin
      fg_color_d   = pick_a;
      fg_alpha_d   = s1_q.faint ? FAINT_ALPHA : FULL_ALPHA;
      bg_visible_d = (s1_q.bg_src != SRC_DEFAULT);
      bg_color_d   = bg_visible_d ? pick_b : '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q && (s1_q.cmd == CMD_RESOLVE);
    end
  end

  always_ff @(posedge clk_i) begin
    fg_color_q   <= fg_color_d;
    fg_alpha_q   <= fg_alpha_d;
    bg_color_q   <= bg_color_d;
    bg_visible_q <= bg_visible_d;
  end

  assign done_o       = done_q;
  assign fg_color_o   = fg_color_q;
  assign fg_alpha_o   = fg_alpha_q;
  assign bg_color_o   = bg_color_q;
  assign bg_visible_o = bg_visible_q;

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without a matching transaction");

  a_valid_implies_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (custom_valid_q & ~use_custom_q) == '0)
    else $error("valid custom entry not selected in base palette");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.cmd == CMD_CLEAR) |=> (custom_valid_q == '0))
    else $error("clear left custom entries valid");

  a_hidden_bg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !bg_visible_o) |-> (bg_color_o == '0))
    else $error("transparent background carries a colour");
`endif

endmodule

`default_nettype wire
